// ===== hw/rtl/scac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scac_pkg
// Types, constants and helpers shared by the Sampson cost accumulator files.
// ----------------------------------------------------------------------------
package scac_pkg;

  localparam int FRAC_BITS_DEF = 16;  // fraction bits of points, r2, thresholds
  localparam int MATRIX_FRAC   = 18;  // fraction bits of matrix entries
  localparam int WEIGHT_FRAC   = 16;  // fraction bits of the point weight
  localparam int ENTRY_W       = 21;  // one matrix entry
  localparam int ROW_W         = 3 * ENTRY_W;
  localparam int COST_W        = 48;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ZERO = 3'd0,
    REG_ROW_ONE  = 3'd1,
    REG_ROW_TWO  = 3'd2,
    REG_THRESH   = 3'd3,
    REG_INV      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [23:0]        point_weight;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [31:0]              squared_error;
    logic signed [COST_W-1:0] running_cost;
    logic                     cost_final;
    logic                     degenerate;
  } out_t;

  // queue entry: the request plus what the front found out about it
  typedef struct packed {
    in_t  item;
    logic zero_wt;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
    logic [ROW_W-1:0] row2;
    logic [31:0]      thresh;
    logic [31:0]      inv;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROJ,
    ST_DEN,
    ST_EPI,
    ST_NUM,
    ST_CHK,
    ST_DIV,
    ST_LOSS,
    ST_WGT
  } back_state_t;

  // signed entry of a packed matrix row, column 0 in the low bits
  function automatic logic signed [ENTRY_W-1:0] entry(input logic [ROW_W-1:0] row,
                                                      input int col);
    entry = $signed(row[ENTRY_W*col +: ENTRY_W]);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scac_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scac_front
// Input stage: takes requests, tags zero-weight points, feeds the queue.
// ----------------------------------------------------------------------------
module scac_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire scac_pkg::in_t   in_data,
  input  wire scac_pkg::qstat_t qstat,
  output scac_pkg::qpush_t     push
);

  logic            fr_valid_r, fr_valid_nxt;
  scac_pkg::qent_t fr_ent_r, fr_ent_nxt;
  logic            accept;

  // hold stage only blocks when it is full and the queue cannot take it
  assign in_stall = fr_valid_r & qstat.full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    fr_valid_nxt = accept | (fr_valid_r & qstat.full);
    fr_ent_nxt   = fr_ent_r;
    if (accept) begin
      fr_ent_nxt.item    = in_data;
      fr_ent_nxt.zero_wt = (in_data.point_weight == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_ent_r <= fr_ent_nxt;
  end

  assign push.valid = fr_valid_r;
  assign push.ent   = fr_ent_r;

endmodule
`default_nettype wire

// ===== hw/rtl/scac_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scac_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module scac_queue #(
  parameter int DEPTH = scac_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scac_pkg::qpush_t push,
  input  wire logic             pop,
  output scac_pkg::qent_t       pop_data,
  output scac_pkg::qstat_t      qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scac_pkg::qent_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push.valid & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign pop_data    = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.ent;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scac_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scac_back
// Sequencer around one shared multiply-accumulate and a radix-2 divider:
// Sampson error, truncated loss, weighted running cost, result register.
// ----------------------------------------------------------------------------
module scac_back #(
  parameter int FRAC_BITS = scac_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scac_pkg::cfg_t   cfg,
  input  wire scac_pkg::qstat_t qstat,
  input  wire scac_pkg::qent_t  pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output scac_pkg::out_t        out_data
);

  localparam int MW = 38;        // multiplier operand
  localparam int PRW = 2 * MW;   // product
  localparam int AW = 80;        // accumulator
  localparam int VW = 38;        // projected values a, b, e, c, d
  localparam int NW = 128;       // numerator and divisor
  localparam int CMW = 64;       // epipolar magnitude
  localparam int CW = scac_pkg::COST_W;
  localparam logic signed [AW-1:0] COST_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AW-1:0] COST_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [63:0] LOSS_LIM = 64'h7FFF_FFFF + (64'd1 << FRAC_BITS);
  localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

  scac_pkg::back_state_t state_r, state_nxt;
  logic [4:0]            step_r, step_nxt;
  scac_pkg::qent_t       item_r, item_nxt;
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic signed [VW-1:0]  proj_r [5];
  logic signed [VW-1:0]  proj_nxt [5];
  logic [AW-1:0]         den_r, den_nxt;
  logic [CMW-1:0]        cmag_r, cmag_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [NW-1:0]         dsh_r, dsh_nxt;
  logic [31:0]           quo_r, quo_nxt;
  logic                  deg_r, deg_nxt;
  logic signed [32:0]    loss_r, loss_nxt;
  logic signed [CW-1:0]  cost_r, cost_nxt;
  logic                  out_valid_r, out_valid_nxt;
  scac_pkg::out_t        out_data_r, out_data_nxt;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0]  psum, csh, cmag_s, wsh, sum;
  logic signed [scac_pkg::ENTRY_W-1:0] ent_a, ent_c;
  logic signed [31:0]    coord;
  logic [63:0]           pval;
  logic                  out_free;

  // matrix entries
  logic signed [scac_pkg::ENTRY_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  assign e00 = scac_pkg::entry(cfg.row0, 0);
  assign e01 = scac_pkg::entry(cfg.row0, 1);
  assign e02 = scac_pkg::entry(cfg.row0, 2);
  assign e10 = scac_pkg::entry(cfg.row1, 0);
  assign e11 = scac_pkg::entry(cfg.row1, 1);
  assign e12 = scac_pkg::entry(cfg.row1, 2);
  assign e20 = scac_pkg::entry(cfg.row2, 0);
  assign e21 = scac_pkg::entry(cfg.row2, 1);
  assign e22 = scac_pkg::entry(cfg.row2, 2);

  // the one shared multiplier
  assign prod     = mul_a * mul_b;
  assign psum     = acc_r + AW'(prod);
  assign out_free = ~out_valid_r | ~out_stall;

  // projection operand table: even steps start a value, odd steps finish it
  always_comb begin
    ent_a = '0;
    ent_c = '0;
    coord = '0;
    case (step_r)
      5'd0:    begin ent_a = e00; ent_c = e02; coord = item_r.item.first_x;  end
      5'd1:    begin ent_a = e01;              coord = item_r.item.first_y;  end
      5'd2:    begin ent_a = e10; ent_c = e12; coord = item_r.item.first_x;  end
      5'd3:    begin ent_a = e11;              coord = item_r.item.first_y;  end
      5'd4:    begin ent_a = e20; ent_c = e22; coord = item_r.item.first_x;  end
      5'd5:    begin ent_a = e21;              coord = item_r.item.first_y;  end
      5'd6:    begin ent_a = e00; ent_c = e20; coord = item_r.item.second_x; end
      5'd7:    begin ent_a = e10;              coord = item_r.item.second_y; end
      5'd8:    begin ent_a = e01; ent_c = e21; coord = item_r.item.second_x; end
      5'd9:    begin ent_a = e11;              coord = item_r.item.second_y; end
      default: begin ent_a = '0;              coord = '0;                   end
    endcase
  end

  // sequencer: next state, datapath updates
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    item_nxt      = item_r;
    acc_nxt       = acc_r;
    proj_nxt      = proj_r;
    den_nxt       = den_r;
    cmag_nxt      = cmag_r;
    num_nxt       = num_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    deg_nxt       = deg_r;
    loss_nxt      = loss_r;
    cost_nxt      = cost_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    csh           = '0;
    cmag_s        = '0;
    wsh           = '0;
    sum           = '0;
    pval          = '0;

    case (state_r)
      scac_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          item_nxt  = pop_data;
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_PROJ;
        end
      end

      // a, b, e, c, d: entry*coord + entry*coord + entry*unit, floor to F bits
      scac_pkg::ST_PROJ: begin
        mul_a = MW'(ent_a);
        mul_b = MW'(coord);
        if (!step_r[0]) begin
          acc_nxt = (AW'(ent_c) <<< FRAC_BITS) + AW'(prod);
        end else begin
          proj_nxt[step_r[3:1]] = VW'(psum >>> scac_pkg::MATRIX_FRAC);
        end
        if (step_r == 5'd9) begin
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_DEN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // denominator a^2 + b^2 + c^2 + d^2
      scac_pkg::ST_DEN: begin
        case (step_r[1:0])
          2'd0:    mul_a = proj_r[0];
          2'd1:    mul_a = proj_r[1];
          2'd2:    mul_a = proj_r[3];
          default: mul_a = proj_r[4];
        endcase
        mul_b = mul_a;
        acc_nxt = (step_r == '0) ? AW'(prod) : psum;
        if (step_r == 5'd3) begin
          den_nxt   = psum;
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_EPI;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // epipolar value x2*a + y2*b + e*unit, floor to F bits, magnitude
      scac_pkg::ST_EPI: begin
        if (step_r == '0) begin
          mul_a    = proj_r[0];
          mul_b    = MW'(item_r.item.second_x);
          acc_nxt  = (AW'(proj_r[2]) <<< FRAC_BITS) + AW'(prod);
          step_nxt = 5'd1;
        end else begin
          mul_a     = proj_r[1];
          mul_b     = MW'(item_r.item.second_y);
          csh       = psum >>> FRAC_BITS;
          cmag_s    = csh[AW-1] ? -csh : csh;
          cmag_nxt  = cmag_s[CMW-1:0];
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_NUM;
        end
      end

      // numerator cmag^2 << F from 32-bit halves
      scac_pkg::ST_NUM: begin
        case (step_r[1:0])
          2'd0: begin
            mul_a   = MW'(cmag_r[63:32]);
            mul_b   = MW'(cmag_r[63:32]);
            num_nxt = {prod[63:0], 64'd0};
          end
          2'd1: begin
            mul_a   = MW'(cmag_r[63:32]);
            mul_b   = MW'(cmag_r[31:0]);
            num_nxt = num_r + (NW'(prod[63:0]) << 33);
          end
          default: begin
            mul_a   = MW'(cmag_r[31:0]);
            mul_b   = MW'(cmag_r[31:0]);
            num_nxt = (num_r + NW'(prod[63:0])) << FRAC_BITS;
          end
        endcase
        if (step_r == 5'd2) begin
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_CHK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // zero denominator or quotient past 32 bits saturates r2
      scac_pkg::ST_CHK: begin
        dsh_nxt = NW'(den_r) << 31;
        quo_nxt = '0;
        if (den_r == '0 || num_r >= (NW'(den_r) << 32)) begin
          deg_nxt   = 1'b1;
          quo_nxt   = '1;
          loss_nxt  = '0;
          state_nxt = scac_pkg::ST_WGT;
        end else begin
          deg_nxt   = 1'b0;
          step_nxt  = '0;
          state_nxt = scac_pkg::ST_DIV;
        end
      end

      // one quotient bit a cycle
      scac_pkg::ST_DIV: begin
        if (num_r >= dsh_r) begin
          num_nxt = num_r - dsh_r;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        if (step_r == 5'd31) begin
          loss_nxt  = '0;
          state_nxt = item_r.zero_wt ? scac_pkg::ST_WGT : scac_pkg::ST_LOSS;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      // truncated loss r2*inv - 1 below the cutoff
      scac_pkg::ST_LOSS: begin
        mul_a = MW'(quo_r);
        mul_b = MW'(cfg.inv);
        pval  = prod[63:0] >> FRAC_BITS;
        if (quo_r < cfg.thresh) begin
          loss_nxt = (pval > LOSS_LIM) ? 33'sh0_7FFF_FFFF : 33'(pval - UNIT);
        end else begin
          loss_nxt = '0;
        end
        state_nxt = scac_pkg::ST_WGT;
      end

      // weight, accumulate with saturation, hand to the result register
      scac_pkg::ST_WGT: begin
        mul_a = MW'(loss_r);
        mul_b = MW'(item_r.item.point_weight);
        wsh   = AW'(prod) >>> scac_pkg::WEIGHT_FRAC;
        sum   = AW'(cost_r) + wsh;
        if (sum > COST_HI) begin
          sum = COST_HI;
        end else if (sum < COST_LO) begin
          sum = COST_LO;
        end
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.squared_error = quo_r;
          out_data_nxt.running_cost  = CW'(sum);
          out_data_nxt.cost_final    = item_r.item.last_point;
          out_data_nxt.degenerate    = deg_r;
          cost_nxt  = item_r.item.last_point ? '0 : CW'(sum);
          state_nxt = scac_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = scac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scac_pkg::ST_IDLE;
      step_r      <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cost_r      <= cost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    proj_r     <= proj_nxt;
    den_r      <= den_nxt;
    cmag_r     <= cmag_nxt;
    num_r      <= num_nxt;
    dsh_r      <= dsh_nxt;
    quo_r      <= quo_nxt;
    deg_r      <= deg_nxt;
    loss_r     <= loss_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sampson_robust_cost_accumulator_core.sv =====
`default_nettype none
// Path: a request is accepted into the front hold stage, popped from the queue, then
//   run through the sequencer states projection, denominator, epipolar, numerator,
//   check, divide, loss and weight; a zero-weight point skips loss, a degenerate one
//   skips divide and loss. The back part finishes one request before it pops the next,
//   bound by the shared multiplier and the one-bit-per-cycle divider.
// Reset (synchronous, rst_n low): control registers, configuration, queue and running cost go to zero.
// ----------------------------------------------------------------------------
// sampson_robust_cost_accumulator_core
// Sampson squared error against a configured essential matrix, truncated
// MLESAC loss, weighted running cost cleared after the last point of a set.
// ----------------------------------------------------------------------------
module sampson_robust_cost_accumulator_core #(
  parameter int FRAC_BITS = scac_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire scac_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output scac_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [scac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scac_pkg::ROW_W-1:0]     cfg_wdata
);

  scac_pkg::cfg_t   cfg_r, cfg_nxt;
  scac_pkg::qpush_t push;
  scac_pkg::qstat_t qstat;
  scac_pkg::qent_t  pop_data;
  logic             pop;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        scac_pkg::REG_ROW_ZERO: cfg_nxt.row0   = cfg_wdata;
        scac_pkg::REG_ROW_ONE:  cfg_nxt.row1   = cfg_wdata;
        scac_pkg::REG_ROW_TWO:  cfg_nxt.row2   = cfg_wdata;
        scac_pkg::REG_THRESH:   cfg_nxt.thresh = cfg_wdata[31:0];
        scac_pkg::REG_INV:      cfg_nxt.inv    = cfg_wdata[31:0];
        default:                cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push)
  );

  scac_queue #(
    .DEPTH (scac_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .pop_data (pop_data),
    .qstat    (qstat)
  );

  scac_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a degenerate point always reports a saturated error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.degenerate || out_data.squared_error == 32'hFFFF_FFFF))
    else $error("degenerate result without saturated error");

  // queue status is consistent
  assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  // input only stalls while the queue is full
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qstat.full)
    else $error("input stalled with room in queue");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== dv/sampson_robust_cost_accumulator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sampson robust cost accumulator testbench
// Streams point correspondences through the core under several matrix and
// threshold settings, predicts each Sampson error, loss and running cost,
// and checks every result in order, with both sides idling at random in some phases.
// ----------------------------------------------------------------------------
module sampson_robust_cost_accumulator_core_tb;

  localparam int F = scac_pkg::FRAC_BITS_DEF;
  localparam int RW = scac_pkg::ROW_W;
  localparam int EW = scac_pkg::ENTRY_W;
  localparam longint COST_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint COST_LO = -COST_HI - 1;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  scac_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scac_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [scac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [RW-1:0] cfg_wdata = '0;

  sampson_robust_cost_accumulator_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // shadow of the configuration and running cost
  logic [RW-1:0] m_row0 = '0, m_row1 = '0, m_row2 = '0;
  logic [31:0] m_thresh = '0, m_inv = '0;
  longint cost_acc = 0;

  scac_pkg::in_t pending_points[$];
  scac_pkg::out_t expected_costs[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;
  bit req_taken = 0;

  function automatic logic signed [127:0] mat_entry(logic [RW-1:0] row, int col);
    logic signed [EW-1:0] v;
    v = row[EW*col +: EW];
    return v;
  endfunction

  // Sampson error, truncated loss and running cost for one request
  function automatic scac_pkg::out_t predict_cost(scac_pkg::in_t it);
    logic signed [127:0] x1, y1, x2, y2, e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [127:0] a, b, ep, c, d, cw;
    logic [127:0] cm, num, den;
    logic [31:0] r2;
    logic [63:0] pu;
    longint loss, wl, sum;
    bit deg;
    scac_pkg::out_t r;
    x1 = it.first_x; y1 = it.first_y; x2 = it.second_x; y2 = it.second_y;
    e00 = mat_entry(m_row0, 0); e01 = mat_entry(m_row0, 1); e02 = mat_entry(m_row0, 2);
    e10 = mat_entry(m_row1, 0); e11 = mat_entry(m_row1, 1); e12 = mat_entry(m_row1, 2);
    e20 = mat_entry(m_row2, 0); e21 = mat_entry(m_row2, 1); e22 = mat_entry(m_row2, 2);
    a  = (e00 * x1 + e01 * y1 + (e02 <<< F)) >>> scac_pkg::MATRIX_FRAC;
    b  = (e10 * x1 + e11 * y1 + (e12 <<< F)) >>> scac_pkg::MATRIX_FRAC;
    ep = (e20 * x1 + e21 * y1 + (e22 <<< F)) >>> scac_pkg::MATRIX_FRAC;
    c  = (e00 * x2 + e10 * y2 + (e20 <<< F)) >>> scac_pkg::MATRIX_FRAC;
    d  = (e01 * x2 + e11 * y2 + (e21 <<< F)) >>> scac_pkg::MATRIX_FRAC;
    cw = (x2 * a + y2 * b + (ep <<< F)) >>> F;
    cm = (cw < 0) ? -cw : cw;
    cm = {64'b0, cm[63:0]};
    num = (cm * cm) << F;
    den = $unsigned(a * a + b * b + c * c + d * d);
    deg = 0;
    r2 = '0;
    if (den == 0 || num >= (den << 32)) begin
      deg = 1;
      r2 = 32'hFFFF_FFFF;
    end else begin
      r2 = 32'(num / den);
    end
    loss = 0;
    if (!deg && r2 < m_thresh) begin
      pu = ({32'b0, r2} * {32'b0, m_inv}) >> F;
      if (pu > 64'h7FFF_FFFF + (64'd1 << F)) loss = 64'sh7FFF_FFFF;
      else loss = longint'(pu) - (longint'(1) << F);
    end
    wl = (loss * longint'({40'b0, it.point_weight})) >>> scac_pkg::WEIGHT_FRAC;
    sum = cost_acc + wl;
    if (sum > COST_HI) sum = COST_HI;
    if (sum < COST_LO) sum = COST_LO;
    r.squared_error = r2;
    r.running_cost = sum[scac_pkg::COST_W-1:0];
    r.cost_final = it.last_point;
    r.degenerate = deg;
    cost_acc = it.last_point ? 0 : sum;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // request accept: predict and queue the expected result
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_costs.push_back(predict_cost(in_data));
      req_taken = 1;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_points.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 0;
  end

  // receiver stall, with a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    scac_pkg::out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_costs.size() == 0) begin
        report_mismatch("unexpected result, error", out_data.squared_error, 0);
      end else begin
        w = expected_costs.pop_front();
        if (out_data.squared_error !== w.squared_error)
          report_mismatch("squared_error", out_data.squared_error, w.squared_error);
        if (out_data.running_cost !== w.running_cost)
          report_mismatch("running_cost", out_data.running_cost, w.running_cost);
        if (out_data.cost_final !== w.cost_final)
          report_mismatch("cost_final", out_data.cost_final, w.cost_final);
        if (out_data.degenerate !== w.degenerate)
          report_mismatch("degenerate", out_data.degenerate, w.degenerate);
      end
    end
  end

  task automatic write_reg(scac_pkg::cfg_reg_t idx, logic [RW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scac_pkg::REG_ROW_ZERO: m_row0 = val;
      scac_pkg::REG_ROW_ONE:  m_row1 = val;
      scac_pkg::REG_ROW_TWO:  m_row2 = val;
      scac_pkg::REG_THRESH:   m_thresh = val[31:0];
      scac_pkg::REG_INV:      m_inv = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [RW-1:0] r0, logic [RW-1:0] r1,
                            logic [RW-1:0] r2, logic [31:0] th, logic [31:0] iv);
    write_reg(scac_pkg::REG_ROW_ZERO, r0);
    write_reg(scac_pkg::REG_ROW_ONE, r1);
    write_reg(scac_pkg::REG_ROW_TWO, r2);
    write_reg(scac_pkg::REG_THRESH, {31'b0, th});
    write_reg(scac_pkg::REG_INV, {31'b0, iv});
  endtask

  // matrix row of small entries, roughly within +-1.0
  function automatic logic [RW-1:0] small_row();
    logic [EW-1:0] e0, e1, e2;
    e0 = EW'($signed($urandom_range(524288)) - 262144);
    e1 = EW'($signed($urandom_range(524288)) - 262144);
    e2 = EW'($signed($urandom_range(524288)) - 262144);
    return {e2, e1, e0};
  endfunction

  function automatic logic [31:0] rand_coord();
    int k;
    k = $urandom_range(9);
    if (k <= 5) return 32'($signed($urandom_range(524288)) - 262144);
    if (k <= 7) return 32'($signed($urandom_range(33554432)) - 16777216);
    if (k == 8) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic scac_pkg::in_t rand_point(bit last);
    scac_pkg::in_t p;
    p.first_x = rand_coord();
    p.first_y = rand_coord();
    p.second_x = rand_coord();
    p.second_y = rand_coord();
    p.point_weight = ($urandom_range(2) == 0) ? 24'd65536 : 24'($urandom);
    p.last_point = last;
    return p;
  endfunction

  // point sets of random length ending in last, with some stray last marks; with no_last no point is last
  task automatic queue_sets(int n, bit no_last);
    int len;
    while (n > 0) begin
      len = $urandom_range(20, 1);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        if (no_last) pending_points.push_back(rand_point(0));
        else pending_points.push_back(rand_point((i == len - 1) || ($urandom_range(19) == 0)));
      end
    end
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_costs.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic scac_pkg::in_t make_point(logic [31:0] x1, logic [31:0] y1,
                                               logic [31:0] x2, logic [31:0] y2,
                                               logic [23:0] w, bit last);
    scac_pkg::in_t p;
    p.first_x = x1; p.first_y = y1; p.second_x = x2; p.second_y = y2;
    p.point_weight = w; p.last_point = last;
    return p;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-zero matrix after reset: zero denominator
    pending_points.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0,
                                        24'd65536, 0));
    pending_points.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                        32'h0, 24'hFF_FFFF, 1));
    drain();

    // realistic matrix, threshold 4.0, directed extremes
    set_config(small_row(), small_row(), small_row(), 32'h0004_0000, 32'h0000_4000);
    pending_points.push_back(make_point(32'h0, 32'h0, 32'h0, 32'h0, 24'd65536, 0));
    pending_points.push_back(make_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                        32'h0001_0000, 24'd0, 0));
    pending_points.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 24'hFF_FFFF, 0));
    pending_points.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 24'hFF_FFFF, 1));
    pending_points.push_back(make_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
                                        32'hFFFF_8000, 24'd65536, 1));
    for (int i = 0; i < 15; i++) pending_points.push_back(rand_point(i % 5 == 4));
    drain();

    // phase A: sender idles lightly, receiver heavily, plus a long hold-off
    send_idle_pct = 10;
    recv_idle_pct = 78;
    hold_cycles = 600;
    queue_sets(300, 0);
    drain();

    // phase B: extreme matrix and thresholds, roles of idling swapped
    set_config({RW{1'b1}}, {1'b0, {(RW-1){1'b1}}}, 63'($urandom) << 31 ^ $urandom,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct = 78;
    recv_idle_pct = 10;
    queue_sets(300, 0);
    drain();

    // zero threshold: every loss is zero
    set_config(small_row(), small_row(), small_row(), 32'h0, 32'h0001_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_sets(100, 0);
    drain();

    // oversized reciprocal and one long set: large losses and cost saturation
    set_config(small_row(), small_row(), small_row(), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_sets(300, 1);
    pending_points.push_back(rand_point(1));
    drain();

    // back to a realistic setting, still with no idling
    set_config(small_row(), small_row(), small_row(), 32'h0010_0000, 32'h0000_1000);
    queue_sets(100, 0);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
